### hdl/ioir_pkg.sv
// Package: shared types, constants and the delivery decode function for the interrupt redirector.
package ioir_pkg;

  localparam logic [2:0] FUNC_READ   = 3'd0;
  localparam logic [2:0] FUNC_WRITE  = 3'd1;
  localparam logic [2:0] FUNC_ASSERT = 3'd2;
  localparam logic [2:0] FUNC_DEASSERT = 3'd3;
  localparam logic [2:0] FUNC_EOI    = 3'd4;

  localparam logic [7:0] SEL_ID      = 8'h00;
  localparam logic [7:0] SEL_VERSION = 8'h01;
  localparam logic [7:0] SEL_ARB     = 8'h02;
  localparam logic [7:0] SEL_ENTRY   = 8'h10;

  localparam logic [15:0] OFF_SELECT_END = 16'h0010;
  localparam logic [15:0] OFF_WINDOW_END = 16'h0020;

  localparam logic [2:0] DM_FIXED  = 3'd0;
  localparam logic [2:0] DM_LOWEST = 3'd1;
  localparam logic [2:0] DM_NMI    = 3'd4;

  localparam int E_MASK_BIT  = 16;
  localparam int E_LEVEL_BIT = 15;
  localparam int E_RIRR_BIT  = 14;
  localparam int E_LOG_BIT   = 11;
  localparam logic [63:0] E_WR_LO = 64'h0000_0000_0001_afff;
  localparam logic [63:0] E_WR_HI = 64'hff00_0000_0000_0000;
  localparam logic [63:0] E_RESET = 64'h0000_0000_0001_0000;

  localparam logic [1:0] REG_NPINS      = 2'd0;
  localparam logic [1:0] REG_INITIAL_ID = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [31:0] read_data;
    logic [7:0]  destination;
    logic        dest_logical;
    logic [7:0]  vector;
    logic        trigger_level;
    logic [4:0]  source_pin;
    logic        pin_unmasked;
    logic        pin_configured;
    logic [7:0]  current_id;
    logic        last;
  } result_t;

  // Decode of one entry for delivery.
  typedef struct packed {
    logic       fire;
    logic       emit;
    logic [7:0] destination;
    logic       set_rirr;
  } dlv_t;

  function automatic dlv_t deliver_decode(logic [63:0] e);
    dlv_t d;
    logic [7:0] dst;
    logic [2:0] dm;
    dst = e[63:56];
    dm = e[10:8];
    d.fire = !e[E_MASK_BIT];
    if (e[E_LOG_BIT]) begin
      if (dm == DM_LOWEST) dst = dst & (~dst + 8'd1);
      d.emit = d.fire && (dst != 8'd0);
      d.set_rirr = d.fire && e[E_LEVEL_BIT];
    end else begin
      d.emit = d.fire && (dm == DM_FIXED || dm == DM_LOWEST || dm == DM_NMI);
      d.set_rirr = d.emit && e[E_LEVEL_BIT];
    end
    d.destination = dst;
    return d;
  endfunction

endpackage

### hdl/ioir_core.sv
// Core sequencer: entry memory, pin marks and one shared entry evaluator.
module ioir_core #(
  parameter int MAX_PINS      = 24,
  parameter int VERSION_VALUE = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] offset,
  input  logic [31:0] write_data,
  input  logic [4:0]  pin,
  input  logic [7:0]  eoi_vector,
  output logic        res_valid,
  input  logic        res_ready,
  output ioir_pkg::result_t res,
  input  logic [4:0]  npins_reg,
  input  logic        id_load,
  input  logic [7:0]  id_load_value
);
  localparam int PW = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_STAT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [63:0] table_mem [MAX_PINS];
  logic [MAX_PINS-1:0] line_level, pending;
  logic [7:0] register_select;
  logic [7:0] apic_id;
  logic [2:0] f;
  logic [15:0] off;
  logic [31:0] wd;
  logic [4:0] pn;
  logic [7:0] ev;
  logic [5:0] scan;
  logic [PW-1:0] cur;
  logic [63:0] ent;
  logic [31:0] rd;
  logic [5:0]  n_used;
  logic        eoi_mode;

  assign n_used = (npins_reg == 5'd0 || 32'(npins_reg) > MAX_PINS) ?
                  6'(MAX_PINS) : {1'b0, npins_reg};
  assign in_ready = (state == S_IDLE);

  logic [7:0]  sel_off;
  logic        sel_entry;
  logic [PW-1:0] sel_pin;
  logic [5:0]  sel_p6;
  assign sel_off = register_select - ioir_pkg::SEL_ENTRY;
  assign sel_p6 = {1'b0, sel_off[7:1]} > 6'd63 ? 6'd0 : sel_off[6:1];
  assign sel_entry = register_select >= ioir_pkg::SEL_ENTRY &&
                     {1'b0, sel_off[7:1]} < {2'b0, n_used};
  assign sel_pin = sel_p6[PW-1:0];

  ioir_pkg::dlv_t dd;
  assign dd = ioir_pkg::deliver_decode(ent);

  logic pin_ok;
  assign pin_ok = {1'b0, pn} < n_used;

  logic eval_fire;
  assign eval_fire = (f == ioir_pkg::FUNC_ASSERT) ?
                     !(table_mem[cur][ioir_pkg::E_LEVEL_BIT] &&
                       table_mem[cur][ioir_pkg::E_RIRR_BIT]) :
                     eoi_mode ? (line_level[cur] && pending[cur]) :
                     (table_mem[cur][ioir_pkg::E_LEVEL_BIT] &&
                      !table_mem[cur][ioir_pkg::E_RIRR_BIT] &&
                      line_level[cur] && pending[cur]);

  logic res_load;
  assign res_load = ((state == S_OUT && dd.emit) || state == S_STAT) &&
                    (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_load) res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      line_level <= '0;
      pending <= '0;
      register_select <= '0;
      scan <= '0;
      for (int i = 0; i < MAX_PINS; i++) table_mem[i] <= ioir_pkg::E_RESET;
    end else begin
      if (id_load) apic_id <= id_load_value;
      case (state)
        S_IDLE: if (in_valid) begin
          f <= func; off <= offset; wd <= write_data; pn <= pin; ev <= eoi_vector;
          rd <= '0;
          eoi_mode <= 1'b0;
          scan <= '0;
          case (func)
            ioir_pkg::FUNC_READ: state <= S_READ;
            ioir_pkg::FUNC_WRITE: state <= S_WRITE;
            ioir_pkg::FUNC_ASSERT, ioir_pkg::FUNC_DEASSERT: state <= S_WRITE;
            ioir_pkg::FUNC_EOI: begin
              eoi_mode <= 1'b1;
              state <= S_SCAN;
            end
            default: state <= S_STAT;
          endcase
        end
        S_READ: begin
          if (off < ioir_pkg::OFF_SELECT_END) rd <= {24'd0, register_select};
          else if (off < ioir_pkg::OFF_WINDOW_END) begin
            if (register_select == ioir_pkg::SEL_ID ||
                register_select == ioir_pkg::SEL_ARB) rd <= {apic_id, 24'd0};
            else if (register_select == ioir_pkg::SEL_VERSION)
              rd <= {11'd0, 5'(n_used - 6'd1), 8'd0, 8'(VERSION_VALUE)};
            else if (sel_entry)
              rd <= register_select[0] ? table_mem[sel_pin][63:32] :
                                         table_mem[sel_pin][31:0];
          end
          state <= S_STAT;
        end
        S_WRITE: begin
          if (f == ioir_pkg::FUNC_WRITE) begin
            if (off < ioir_pkg::OFF_SELECT_END) begin
              register_select <= wd[7:0];
              state <= S_STAT;
            end else if (off < ioir_pkg::OFF_WINDOW_END &&
                         register_select == ioir_pkg::SEL_ID) begin
              apic_id <= {4'd0, wd[27:24]};
              state <= S_STAT;
            end else if (off < ioir_pkg::OFF_WINDOW_END && sel_entry) begin
              if (register_select[0])
                table_mem[sel_pin] <= (table_mem[sel_pin] & ~ioir_pkg::E_WR_HI) |
                                      ({wd, 32'd0} & ioir_pkg::E_WR_HI);
              else
                table_mem[sel_pin] <= (table_mem[sel_pin] & ~ioir_pkg::E_WR_LO) |
                                      ({32'd0, wd} & ioir_pkg::E_WR_LO);
              cur <= sel_pin;
              state <= S_EVAL;
            end else state <= S_STAT;
          end else if (pin_ok && f == ioir_pkg::FUNC_ASSERT) begin
            line_level[pn[PW-1:0]] <= 1'b1;
            pending[pn[PW-1:0]] <= 1'b1;
            cur <= pn[PW-1:0];
            state <= S_EVAL;
          end else begin
            if (pin_ok) line_level[pn[PW-1:0]] <= 1'b0;
            state <= S_STAT;
          end
        end
        S_EVAL: begin
          ent <= table_mem[cur];
          if (eval_fire) state <= S_OUT;
          else if (eoi_mode) state <= S_SCAN;
          else state <= S_STAT;
        end
        S_SCAN: begin
          if (scan >= n_used) state <= S_STAT;
          else begin
            scan <= scan + 6'd1;
            if (table_mem[scan[PW-1:0]][ioir_pkg::E_LEVEL_BIT] &&
                table_mem[scan[PW-1:0]][7:0] == ev &&
                table_mem[scan[PW-1:0]][ioir_pkg::E_RIRR_BIT]) begin
              table_mem[scan[PW-1:0]][ioir_pkg::E_RIRR_BIT] <= 1'b0;
              cur <= scan[PW-1:0];
              state <= S_EVAL;
            end
          end
        end
        S_OUT: if (!res_valid || res_ready) begin
          if (dd.fire) pending[cur] <= 1'b0;
          if (dd.set_rirr) table_mem[cur][ioir_pkg::E_RIRR_BIT] <= 1'b1;
          if (dd.emit) begin
            res <= '{kind: 1'b1, read_data: 32'd0, destination: dd.destination,
                     dest_logical: ent[ioir_pkg::E_LOG_BIT], vector: ent[7:0],
                     trigger_level: ent[ioir_pkg::E_LEVEL_BIT],
                     source_pin: 5'(cur), pin_unmasked: 1'b0,
                     pin_configured: 1'b0, current_id: apic_id, last: 1'b0};
          end
          state <= eoi_mode ? S_SCAN : S_STAT;
        end
        S_STAT: if (!res_valid || res_ready) begin
          res <= '{kind: 1'b0, read_data: rd, destination: 8'd0,
                   dest_logical: 1'b0, vector: 8'd0, trigger_level: 1'b0,
                   source_pin: 5'd0,
                   pin_unmasked: pin_ok && !table_mem[pn[PW-1:0]][ioir_pkg::E_MASK_BIT],
                   pin_configured: pin_ok && (table_mem[pn[PW-1:0]][7:0] != 8'd0),
                   current_id: apic_id, last: 1'b1};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    if (rst) apic_id <= id_load_value;
  end
endmodule

### hdl/io_interrupt_redirector.sv
// Top level: APB registers, operation sequencer and result port.
//   channel | direction | handshake        | fields
//   in      | input     | in_valid/in_ready | func offset write_data pin eoi_vector
//   out     | output    | out_valid/out_ready | kind ... last
//   apb     | input     | psel/penable     | paddr pwdata prdata
// Read: READ, STAT. Unknown op: STAT. Write, assert, deassert: WRITE, EVAL if an entry
// is evaluated, OUT if it fires, STAT. EOI re-evaluates entries whose remote IRR clears.
// Reset is synchronous; the entry table reloads during reset itself.
// Each result waits in the output register until taken; the sequencer stalls then.
module io_interrupt_redirector #(
  parameter int MAX_PINS      = 24,
  parameter int VERSION_VALUE = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] offset,
  input  logic [31:0] write_data,
  input  logic [4:0]  pin,
  input  logic [7:0]  eoi_vector,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [31:0] read_data,
  output logic [7:0]  destination,
  output logic        dest_logical,
  output logic [7:0]  vector,
  output logic        trigger_level,
  output logic [4:0]  source_pin,
  output logic        pin_unmasked,
  output logic        pin_configured,
  output logic [7:0]  current_id,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] npins_reg;
  logic [7:0] initial_id;
  logic       wr, id_load;
  ioir_pkg::result_t res;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign id_load = wr && paddr[2:2] == ioir_pkg::REG_INITIAL_ID[0:0] && paddr[1:0] == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      npins_reg <= 5'd24;
      initial_id <= 8'd0;
    end else if (wr && paddr[1:0] == 2'd0) begin
      if (paddr[2] == ioir_pkg::REG_NPINS[0]) npins_reg <= pwdata[4:0];
      else initial_id <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == ioir_pkg::REG_NPINS[0]) prdata = {27'd0, npins_reg};
    else prdata = {24'd0, initial_id};
  end

  ioir_core #(.MAX_PINS(MAX_PINS), .VERSION_VALUE(VERSION_VALUE)) u_core (
    .clk, .rst, .in_valid, .in_ready, .func, .offset, .write_data, .pin,
    .eoi_vector, .res_valid(out_valid), .res_ready(out_ready), .res,
    .npins_reg,
    .id_load(id_load || rst), .id_load_value(rst ? 8'd0 : pwdata[7:0])
  );

  assign kind = res.kind;
  assign read_data = res.read_data;
  assign destination = res.destination;
  assign dest_logical = res.dest_logical;
  assign vector = res.vector;
  assign trigger_level = res.trigger_level;
  assign source_pin = res.source_pin;
  assign pin_unmasked = res.pin_unmasked;
  assign pin_configured = res.pin_configured;
  assign current_id = res.current_id;
  assign last = res.last;
endmodule

### hdl/ioir_checker.sv
// Checker: port-level properties of the interrupt redirector.
module ioir_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic kind,
  input logic last,
  input logic [31:0] read_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("out word dropped");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == !kind)) else $error("last mismatch");
  a_dlv_rd: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> read_data == 32'd0) else $error("delivery read data");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
endmodule

bind io_interrupt_redirector ioir_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .kind, .last, .read_data
);

### tb/sv/io_interrupt_redirector_test.sv
`timescale 1ns / 1ps
// Testbench for the interrupt redirector: random and directed operations, checked against a predictor.
module io_interrupt_redirector_test;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] offset;
    logic [31:0] write_data;
    logic [4:0]  pin;
    logic [7:0]  eoi_vector;
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] read_data;
    logic [7:0]  destination;
    logic        dest_logical;
    logic [7:0]  vector;
    logic        trigger_level;
    logic [4:0]  source_pin;
    logic        pin_unmasked;
    logic        pin_configured;
    logic [7:0]  current_id;
    logic        last;
  } word_t;

  localparam int NPINS = 24;
  localparam int VERSION = 17;
  localparam int LIMIT = 400000;
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] func = 0;
  logic [15:0] offset = 0;
  logic [31:0] write_data = 0;
  logic [4:0] pin = 0;
  logic [7:0] eoi_vector = 0;
  logic kind, dest_logical, trigger_level, pin_unmasked, pin_configured, last;
  logic [31:0] read_data;
  logic [7:0] destination, vector, current_id;
  logic [4:0] source_pin;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  io_interrupt_redirector i_dut (.*);

  initial forever #10 clk = ~clk;

  // predictor state
  logic [63:0] tbl [NPINS];
  logic [23:0] line_hi, armed;
  logic [7:0]  sel, id_now;
  logic [4:0]  cnt_reg;
  word_t expected_words [$];
  op_t   pending_ops [$];
  int errors = 0, cycles = 0, n_words = 0, n_deliv = 0, n_ops = 0;
  bit driving = 0;

  function automatic int used_pins();
    return (cnt_reg == 5'd0 || cnt_reg > NPINS) ? NPINS : int'(cnt_reg);
  endfunction

  function automatic void push_word(word_t w);
    w.current_id = id_now;
    expected_words.push_back(w);
  endfunction

  function automatic void route_entry(int p);
    logic [63:0] e;
    logic [7:0] dst;
    logic [2:0] dm;
    word_t w;
    e = tbl[p];
    if (e[ioir_pkg::E_MASK_BIT]) return;
    armed[p] = 1'b0;
    dm = e[10:8];
    dst = e[63:56];
    w = '0;
    w.kind = 1'b1;
    w.vector = e[7:0];
    w.trigger_level = e[ioir_pkg::E_LEVEL_BIT];
    w.source_pin = 5'(p);
    if (e[ioir_pkg::E_LOG_BIT]) begin
      if (dm == ioir_pkg::DM_LOWEST) dst = dst & (~dst + 8'd1);
      w.destination = dst;
      w.dest_logical = 1'b1;
      if (dst != 8'd0) push_word(w);
    end else begin
      if (dm != ioir_pkg::DM_FIXED && dm != ioir_pkg::DM_LOWEST &&
          dm != ioir_pkg::DM_NMI) return;
      w.destination = dst;
      push_word(w);
    end
    if (e[ioir_pkg::E_LEVEL_BIT]) tbl[p][ioir_pkg::E_RIRR_BIT] = 1'b1;
  endfunction

  function automatic void predict_op(op_t o);
    int n, p;
    logic [31:0] rd;
    logic [63:0] e;
    word_t w;
    n = used_pins();
    rd = 0;
    case (o.func)
      ioir_pkg::FUNC_READ: begin
        if (o.offset < ioir_pkg::OFF_SELECT_END) rd = {24'd0, sel};
        else if (o.offset < ioir_pkg::OFF_WINDOW_END) begin
          if (sel == ioir_pkg::SEL_ID || sel == ioir_pkg::SEL_ARB) rd = {id_now, 24'd0};
          else if (sel == ioir_pkg::SEL_VERSION)
            rd = 32'(VERSION) | (32'(n - 1) << 16);
          else if (sel >= ioir_pkg::SEL_ENTRY && int'(sel) < 16 + 2 * n) begin
            p = (int'(sel) - 16) >> 1;
            rd = sel[0] ? tbl[p][63:32] : tbl[p][31:0];
          end
        end
      end
      ioir_pkg::FUNC_WRITE: begin
        if (o.offset < ioir_pkg::OFF_SELECT_END) sel = o.write_data[7:0];
        else if (o.offset < ioir_pkg::OFF_WINDOW_END) begin
          if (sel == ioir_pkg::SEL_ID) id_now = {4'd0, o.write_data[27:24]};
          else if (sel >= ioir_pkg::SEL_ENTRY && int'(sel) < 16 + 2 * n) begin
            p = (int'(sel) - 16) >> 1;
            if (sel[0])
              tbl[p] = (tbl[p] & ~ioir_pkg::E_WR_HI) |
                       ({o.write_data, 32'd0} & ioir_pkg::E_WR_HI);
            else tbl[p] = (tbl[p] & ~ioir_pkg::E_WR_LO) |
                          ({32'd0, o.write_data} & ioir_pkg::E_WR_LO);
            e = tbl[p];
            if (!e[ioir_pkg::E_MASK_BIT] && e[ioir_pkg::E_LEVEL_BIT] &&
                !e[ioir_pkg::E_RIRR_BIT] && line_hi[p] && armed[p]) route_entry(p);
          end
        end
      end
      ioir_pkg::FUNC_ASSERT: if (int'(o.pin) < n) begin
        line_hi[o.pin] = 1'b1;
        armed[o.pin] = 1'b1;
        e = tbl[o.pin];
        if (!e[ioir_pkg::E_LEVEL_BIT] || !e[ioir_pkg::E_RIRR_BIT]) route_entry(int'(o.pin));
      end
      ioir_pkg::FUNC_DEASSERT: if (int'(o.pin) < n) line_hi[o.pin] = 1'b0;
      ioir_pkg::FUNC_EOI: for (p = 0; p < n; p++) begin
        e = tbl[p];
        if (e[ioir_pkg::E_LEVEL_BIT] && e[7:0] == o.eoi_vector &&
            e[ioir_pkg::E_RIRR_BIT]) begin
          tbl[p][ioir_pkg::E_RIRR_BIT] = 1'b0;
          if (line_hi[p] && armed[p]) route_entry(p);
        end
      end
      default: ;
    endcase
    w = '0;
    w.read_data = rd;
    w.last = 1'b1;
    if (int'(o.pin) < used_pins()) begin
      w.pin_unmasked = !tbl[o.pin][ioir_pkg::E_MASK_BIT];
      w.pin_configured = tbl[o.pin][7:0] != 8'd0;
    end
    push_word(w);
  endfunction

  // handshake sampled at the rising edge, acted on at the next falling edge
  logic in_ready_s = 0;

  // driver: bursts and gaps
  int gap = 0, burst = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_s) begin
        void'(pending_ops.pop_front());
      end
      if (!(in_valid && !in_ready_s)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 0;
        end else if (driving && pending_ops.size() > 0) begin
          in_valid <= 1;
          {func, offset, write_data, pin, eoi_vector} <= pending_ops[0];
          if (burst <= 1) begin
            burst <= $urandom_range(1, 12);
            gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else burst <= burst - 1;
        end else in_valid <= 0;
      end
      case ((cycles >> 7) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= (cycles % 5) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_ready_s <= in_ready;
    if (!rst && in_valid && in_ready) begin
      predict_op(pending_ops[0]);
      n_ops <= n_ops + 1;
    end
    if (!rst && out_valid && out_ready) begin
      word_t got, want;
      got = {kind, read_data, destination, dest_logical, vector, trigger_level,
             source_pin, pin_unmasked, pin_configured, current_id, last};
      n_words <= n_words + 1;
      if (kind) n_deliv <= n_deliv + 1;
      if (expected_words.size() == 0) begin
        $error("unexpected word kind=%0d vector=%0h", kind, vector);
        errors <= errors + 1;
      end else begin
        want = expected_words.pop_front();
        if (got.kind != want.kind) $error("kind exp %0h got %0h", want.kind, got.kind);
        if (got.read_data != want.read_data)
          $error("read_data exp %0h got %0h", want.read_data, got.read_data);
        if (got.destination != want.destination)
          $error("destination exp %0h got %0h", want.destination, got.destination);
        if (got.dest_logical != want.dest_logical)
          $error("dest_logical exp %0h got %0h", want.dest_logical, got.dest_logical);
        if (got.vector != want.vector)
          $error("vector exp %0h got %0h", want.vector, got.vector);
        if (got.trigger_level != want.trigger_level)
          $error("trigger_level exp %0h got %0h", want.trigger_level, got.trigger_level);
        if (got.source_pin != want.source_pin)
          $error("source_pin exp %0h got %0h", want.source_pin, got.source_pin);
        if (got.pin_unmasked != want.pin_unmasked)
          $error("pin_unmasked exp %0h got %0h", want.pin_unmasked, got.pin_unmasked);
        if (got.pin_configured != want.pin_configured)
          $error("pin_configured exp %0h got %0h", want.pin_configured,
                 got.pin_configured);
        if (got.current_id != want.current_id)
          $error("current_id exp %0h got %0h", want.current_id, got.current_id);
        if (got.last != want.last) $error("last exp %0h got %0h", want.last, got.last);
        if (got != want) errors <= errors + 1;
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; pwdata <= val;
    paddr <= 3'({idx, 2'b00});
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == ioir_pkg::REG_NPINS) cnt_reg = val[4:0];
    else begin
      id_now = val[7:0];
    end
  endtask

  function automatic op_t mk(logic [2:0] f, logic [15:0] o, logic [31:0] d,
                             logic [4:0] p, logic [7:0] v);
    op_t x;
    x.func = f; x.offset = o; x.write_data = d; x.pin = p; x.eoi_vector = v;
    return x;
  endfunction

  // entry programming: select high, write, select low, write
  task automatic prog_entry(int p, logic [31:0] lo, logic [7:0] dst);
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'd0,
                             32'(ioir_pkg::SEL_ENTRY) + 32'(2 * p + 1), 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'h10, {dst, 24'hffffff}, 5'(p), 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'd0,
                             32'(ioir_pkg::SEL_ENTRY) + 32'(2 * p), 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'h10, lo, 5'(p), 8'd0));
  endtask

  task automatic run_phase();
    driving = 1;
    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    driving = 0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_entry_lo();
    logic [31:0] v;
    v = $urandom;
    v[7:0] = $urandom_range(0, 7) == 0 ? 8'd0 : 8'($urandom_range(16, 23));
    v[10:8] = $urandom_range(0, 3) == 0 ? 3'($urandom) :
              3'(ioir_pkg::DM_FIXED + $urandom_range(0, 1));
    v[16] = $urandom_range(0, 4) == 0;
    return v;
  endfunction

  task automatic random_ops(int count);
    int k, p, r;
    for (k = 0; k < count; k++) begin
      p = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        prog_entry(p, rand_entry_lo(), 8'($urandom));
        k += 3;
      end else if (r < 35) pending_ops.push_back(mk(ioir_pkg::FUNC_ASSERT, 16'($urandom),
                                                    $urandom, 5'(p), 8'($urandom)));
      else if (r < 50) pending_ops.push_back(mk(ioir_pkg::FUNC_DEASSERT, 16'($urandom),
                                                $urandom, 5'(p), 8'($urandom)));
      else if (r < 70) pending_ops.push_back(mk(ioir_pkg::FUNC_EOI, 16'($urandom), $urandom,
                                                5'($urandom_range(0, 31)),
                                                8'($urandom_range(16, 23))));
      else if (r < 78) pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE,
                                                16'($urandom_range(0, 15)),
                                                $urandom_range(0, 2) == 0 ? $urandom :
                                                $urandom_range(0, 64), 5'd0, 8'd0));
      else if (r < 90) pending_ops.push_back(mk(ioir_pkg::FUNC_READ,
                                                16'($urandom_range(0, 31)), $urandom,
                                                5'($urandom), 8'($urandom)));
      else pending_ops.push_back(mk(3'($urandom), 16'($urandom), $urandom, 5'($urandom),
                                    8'($urandom)));
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < NPINS; k++) tbl[k] = ioir_pkg::E_RESET;
    line_hi = 0; armed = 0; sel = 0; id_now = 0; cnt_reg = 5'd24;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'd0, 32'd0, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'h10, 32'd0, 5'd31, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'd0, 32'hffff_ff01, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'h1f, 32'd0, 5'd23, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'd0, {24'd0, ioir_pkg::SEL_ID},
                             5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'h10, 32'hffff_ffff, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'h10, 32'd0, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'hffff, 32'hffff_ffff, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'h20, 32'd0, 5'd0, 8'd0));
    prog_entry(0, 32'h0000_0030, 8'h05);              // edge fixed physical
    pending_ops.push_back(mk(ioir_pkg::FUNC_ASSERT, 16'd0, 32'd0, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_ASSERT, 16'd0, 32'd0, 5'd0, 8'd0)); // edge redelivers
    prog_entry(1, 32'h0000_8931, 8'hc0);              // level logical lowest
    pending_ops.push_back(mk(ioir_pkg::FUNC_ASSERT, 16'd0, 32'd0, 5'd1, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_ASSERT, 16'd0, 32'd0, 5'd1, 8'd0)); // blocked by remote IRR
    pending_ops.push_back(mk(ioir_pkg::FUNC_EOI, 16'd0, 32'd0, 5'd1, 8'h31));
    pending_ops.push_back(mk(FUNC_UNUSED, 16'hffff, 32'hffff_ffff, 5'd31, 8'hff));
    run_phase();

    apb_write(ioir_pkg::REG_INITIAL_ID, 32'd255);
    apb_write(ioir_pkg::REG_NPINS, 32'd1);
    pending_ops.push_back(mk(ioir_pkg::FUNC_ASSERT, 16'd0, 32'd0, 5'd5, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'd0, 32'h12, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'h10, 32'd0, 5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_WRITE, 16'd0, {24'd0, ioir_pkg::SEL_VERSION},
                             5'd0, 8'd0));
    pending_ops.push_back(mk(ioir_pkg::FUNC_READ, 16'h10, 32'd0, 5'd0, 8'd0));
    run_phase();

    apb_write(ioir_pkg::REG_NPINS, 32'd0);
    apb_write(ioir_pkg::REG_INITIAL_ID, 32'd0);
    random_ops(70);
    run_phase();
    apb_write(ioir_pkg::REG_NPINS, 32'd5);
    apb_write(ioir_pkg::REG_INITIAL_ID, 32'h5a);
    random_ops(60);
    run_phase();
    apb_write(ioir_pkg::REG_NPINS, 32'd31);
    random_ops(60);
    run_phase();

    $display("covered %0d operations, %0d words, %0d deliveries", n_ops, n_words,
             n_deliv);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
